// ===== sv/fixed_string_line_filter_assert.svh =====
// Assertion macros for the line filter. Define SYNTH to drop them.
`ifndef FIXED_STRING_LINE_FILTER_ASSERT_SVH
`define FIXED_STRING_LINE_FILTER_ASSERT_SVH

`ifndef SYNTH
// Property that must hold at every edge out of reset.
`define FSL_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("fixed_string_line_filter: assertion failed");
// Condition that must never be true out of reset.
`define FSL_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("fixed_string_line_filter: forbidden condition seen");
`else
`define FSL_ASSERT(lbl, prop)
`define FSL_NEVER(lbl, cond)
`endif

`endif

// ===== sv/fsl_pkg.sv =====
package fsl_pkg;

  localparam int MAX_PATTERN   = 32;
  localparam int LINE_CAPACITY = 2048;
  localparam int PAT_BITS      = MAX_PATTERN * 8;
  localparam int LEN_W         = 6;
  localparam int CELL_IDX_W    = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam int BYTES_W       = $clog2(LINE_CAPACITY);
  localparam int CNT_W         = 32;
  localparam int FIFO_DEPTH    = 4;
  localparam int FIFO_PTR_W    = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W    = $clog2(FIFO_DEPTH + 1);

  localparam logic [7:0] NEWLINE_BYTE = 8'h0A;
  localparam logic [7:0] UPPER_A      = 8'h41;
  localparam logic [7:0] UPPER_Z      = 8'h5A;
  localparam logic [7:0] CASE_OFFSET  = 8'd32;

  localparam logic REQ_TEXT = 1'b0;
  localparam logic REQ_END  = 1'b1;

  localparam logic KIND_LINE  = 1'b0;
  localparam logic KIND_COUNT = 1'b1;

  typedef enum logic [2:0] {
    REG_PATTERN_LENGTH = 3'd0,
    REG_PATTERN_WORD0  = 3'd1,
    REG_PATTERN_WORD1  = 3'd2,
    REG_PATTERN_WORD2  = 3'd3,
    REG_PATTERN_WORD3  = 3'd4,
    REG_IGNORE_CASE    = 3'd5,
    REG_INVERT_MATCH   = 3'd6
  } cfg_reg_t;

  // Control for the matcher row, one byte per cycle while input is not stalled.
  typedef struct packed {
    logic             advance;
    logic             clear;
    logic [7:0]       data;
    logic             ignore_case;
    logic [LEN_W-1:0] active_len;
  } chain_ctrl_t;

  // Result entry; value is the line number or the match total by kind.
  typedef struct packed {
    logic             kind;
    logic [CNT_W-1:0] value;
    logic             truncated;
    logic             last;
  } result_t;

  function automatic logic [7:0] fold_byte(input logic [7:0] b, input logic ic);
    if (ic && b >= UPPER_A && b <= UPPER_Z) begin
      return b + CASE_OFFSET;
    end
    return b;
  endfunction

endpackage

// ===== sv/fsl_match_cell.sv =====
module fsl_match_cell (
  input  logic                          clk,
  input  logic                          rst_n,
  input  fsl_pkg::chain_ctrl_t          ctrl,
  input  logic [7:0]                    data_folded,
  input  logic [fsl_pkg::CELL_IDX_W-1:0] cell_idx,
  input  logic [7:0]                    pat_byte,
  input  logic                          prev_hit,
  output logic                          hit_r,
  output logic                          tail_hit
);
  import fsl_pkg::*;

  logic             enabled;
  logic             eq;
  logic             hit_nxt;
  logic [LEN_W-1:0] pos;

  assign pos     = LEN_W'(cell_idx);
  assign enabled = pos < ctrl.active_len;
  assign eq      = enabled && (fold_byte(pat_byte, ctrl.ignore_case) == data_folded);

  always_comb begin
    hit_nxt = hit_r;
    if (ctrl.clear) begin
      hit_nxt = 1'b0;
    end else if (ctrl.advance) begin
      hit_nxt = prev_hit & eq;
    end
  end

  // full pattern ends at this byte when this cell is the last one in use
  assign tail_hit = ctrl.advance && !ctrl.clear && hit_nxt &&
                    ((pos + LEN_W'(1)) == ctrl.active_len);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_r <= 1'b0;
    end else begin
      hit_r <= hit_nxt;
    end
  end

endmodule

// ===== sv/fsl_match_chain.sv =====
module fsl_match_chain (
  input  logic                          clk,
  input  logic                          rst_n,
  input  fsl_pkg::chain_ctrl_t          ctrl,
  input  logic [fsl_pkg::PAT_BITS-1:0]  pattern,
  output logic                          found
);
  import fsl_pkg::*;

  logic [MAX_PATTERN-1:0] hits;
  logic [MAX_PATTERN-1:0] tails;
  logic [7:0]             data_folded;

  assign data_folded = fold_byte(ctrl.data, ctrl.ignore_case);

  for (genvar i = 0; i < MAX_PATTERN; i++) begin : g_cell
    logic prev;
    if (i == 0) begin : g_head
      assign prev = 1'b1;
    end else begin : g_body
      assign prev = hits[i-1];
    end

    fsl_match_cell u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .ctrl        (ctrl),
      .data_folded (data_folded),
      .cell_idx    (CELL_IDX_W'(i)),
      .pat_byte    (pattern[i*8 +: 8]),
      .prev_hit    (prev),
      .hit_r       (hits[i]),
      .tail_hit    (tails[i])
    );
  end

  assign found = |tails;

endmodule

// ===== sv/fsl_out_fifo.sv =====
`include "fixed_string_line_filter_assert.svh"

module fsl_out_fifo (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [1:0]        push_cnt,
  input  fsl_pkg::result_t  push0,
  input  fsl_pkg::result_t  push1,
  input  logic              pop,
  output logic              not_empty,
  output logic              almost_full,
  output fsl_pkg::result_t  head
);
  import fsl_pkg::*;

  result_t                mem_r [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0]  wptr_r, wptr_nxt;
  logic [FIFO_PTR_W-1:0]  rptr_r, rptr_nxt;
  logic [FIFO_CNT_W-1:0]  count_r, count_nxt;
  logic [FIFO_PTR_W-1:0]  wptr_plus1;

  assign wptr_plus1  = wptr_r + FIFO_PTR_W'(1);
  assign not_empty   = count_r != '0;
  // room for two entries is needed before taking an item
  assign almost_full = count_r > FIFO_CNT_W'(FIFO_DEPTH - 2);
  assign head        = mem_r[rptr_r];

  assign wptr_nxt  = wptr_r + FIFO_PTR_W'(push_cnt);
  assign rptr_nxt  = rptr_r + FIFO_PTR_W'(pop);
  assign count_nxt = count_r + FIFO_CNT_W'(push_cnt) - FIFO_CNT_W'(pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      wptr_r  <= wptr_nxt;
      rptr_r  <= rptr_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_cnt != 2'd0) begin
      mem_r[wptr_r] <= push0;
    end
    if (push_cnt == 2'd2) begin
      mem_r[wptr_plus1] <= push1;
    end
  end

  `FSL_ASSERT(a_count_bound, count_r <= FIFO_CNT_W'(FIFO_DEPTH))
  `FSL_NEVER(a_pop_empty, pop && count_r == '0)
  `FSL_NEVER(a_push_overflow, (FIFO_CNT_W + 1)'(count_r) + (FIFO_CNT_W + 1)'(push_cnt)
             > (FIFO_CNT_W + 1)'(FIFO_DEPTH) + (FIFO_CNT_W + 1)'(pop))
  `FSL_ASSERT(a_drain, (pop && push_cnt == 2'd0) |=> count_r == $past(count_r) - 1'b1)

endmodule

// ===== sv/fixed_string_line_filter.sv =====
// Output: a line report or count is registered into the result queue and shows on
//   out_* from its head; an end request with an open selected line gives two items.
// Throughput: one input item per cycle; the matcher row updates every prefix bit
//   in the same cycle, and the 4-entry result queue stalls input when under 2 free.
// Reset: synchronous, active low; clears config, counters, line state, queue.
`include "fixed_string_line_filter_assert.svh"

module fixed_string_line_filter (
  input  logic                 clk,
  input  logic                 rst_n,
  // input channel
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 in_req_type,
  input  logic [7:0]           in_data_byte,
  // result channel
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 out_result_kind,
  output logic [31:0]          out_line_number,
  output logic                 out_was_truncated,
  output logic [31:0]          out_match_total,
  output logic                 out_last,
  // configuration write channel
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [2:0]           cfg_index,
  input  logic [63:0]          cfg_data
);
  import fsl_pkg::*;

  // configuration registers
  logic [LEN_W-1:0]    pat_len_r;
  logic [PAT_BITS-1:0] pattern_r;
  logic [255:0]        pat_words_r;
  logic                ignore_case_r;
  logic                invert_r;

  // per-line and per-stream state
  logic                found_r, found_nxt;
  logic [BYTES_W-1:0]  bytes_r, bytes_nxt;
  logic                ovf_r, ovf_nxt;
  logic [CNT_W-1:0]    seen_r, seen_nxt;
  logic [CNT_W-1:0]    sel_r, sel_nxt;

  logic                in_acc;
  logic                is_text, is_newline, is_end;
  logic                has_room;
  logic                finish;
  logic                hit, selected;
  logic [CNT_W-1:0]    seen_inc, sel_inc;
  logic [LEN_W-1:0]    active_len;
  logic                chain_found;
  chain_ctrl_t         ctrl;

  logic [1:0]          push_cnt;
  result_t             push0, push1, head;
  logic                fifo_ne, fifo_af;

  assign cfg_ready = 1'b1;

  // config writes; an index past the list is dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_len_r     <= '0;
      pat_words_r   <= '0;
      ignore_case_r <= 1'b0;
      invert_r      <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_PATTERN_LENGTH: pat_len_r           <= cfg_data[LEN_W-1:0];
        REG_PATTERN_WORD0:  pat_words_r[63:0]    <= cfg_data;
        REG_PATTERN_WORD1:  pat_words_r[127:64]  <= cfg_data;
        REG_PATTERN_WORD2:  pat_words_r[191:128] <= cfg_data;
        REG_PATTERN_WORD3:  pat_words_r[255:192] <= cfg_data;
        REG_IGNORE_CASE:    ignore_case_r       <= cfg_data[0];
        REG_INVERT_MATCH:   invert_r            <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign pattern_r = pat_words_r[PAT_BITS-1:0];

  // lengths past the row act as a full row
  assign active_len = (pat_len_r > LEN_W'(MAX_PATTERN)) ? LEN_W'(MAX_PATTERN) : pat_len_r;

  // input decode
  assign in_stall   = fifo_af;
  assign in_acc     = in_valid && !in_stall;
  assign is_text    = in_acc && (in_req_type == REQ_TEXT) && (in_data_byte != NEWLINE_BYTE);
  assign is_newline = in_acc && (in_req_type == REQ_TEXT) && (in_data_byte == NEWLINE_BYTE);
  assign is_end     = in_acc && (in_req_type == REQ_END);
  assign has_room   = bytes_r < BYTES_W'(LINE_CAPACITY - 1);

  // a line closes on newline, or at end of input when it holds bytes
  assign finish = is_newline || (is_end && bytes_r != '0);

  assign ctrl.advance     = is_text && has_room;
  assign ctrl.clear       = is_newline || is_end;
  assign ctrl.data        = in_data_byte;
  assign ctrl.ignore_case = ignore_case_r;
  assign ctrl.active_len  = active_len;

  fsl_match_chain u_chain (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctrl    (ctrl),
    .pattern (pattern_r),
    .found   (chain_found)
  );

  // empty pattern matches every line, also an empty one
  assign hit      = found_r || (active_len == '0);
  assign selected = hit != invert_r;
  assign seen_inc = (seen_r == '1) ? seen_r : seen_r + CNT_W'(1);
  assign sel_inc  = (sel_r  == '1) ? sel_r  : sel_r  + CNT_W'(1);

  always_comb begin
    found_nxt = found_r;
    bytes_nxt = bytes_r;
    ovf_nxt   = ovf_r;
    seen_nxt  = seen_r;
    sel_nxt   = sel_r;
    push_cnt  = 2'd0;

    push0.kind      = KIND_LINE;
    push0.value     = seen_inc;
    push0.truncated = ovf_r;
    push0.last      = is_newline;

    push1.kind      = KIND_COUNT;
    push1.value     = (finish && selected) ? sel_inc : sel_r;
    push1.truncated = 1'b0;
    push1.last      = 1'b1;

    if (is_text) begin
      if (has_room) begin
        bytes_nxt = bytes_r + BYTES_W'(1);
        found_nxt = found_r | chain_found;
      end else begin
        ovf_nxt = 1'b1;
      end
    end

    if (finish) begin
      seen_nxt = seen_inc;
      if (selected) begin
        sel_nxt  = sel_inc;
        push_cnt = 2'd1;
      end
    end

    if (is_newline || is_end) begin
      found_nxt = 1'b0;
      bytes_nxt = '0;
      ovf_nxt   = 1'b0;
    end

    if (is_end) begin
      seen_nxt = '0;
      sel_nxt  = '0;
      if (push_cnt == 2'd1) begin
        push_cnt = 2'd2;
      end else begin
        push_cnt = 2'd1;
        push0    = push1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r <= 1'b0;
      bytes_r <= '0;
      ovf_r   <= 1'b0;
      seen_r  <= '0;
      sel_r   <= '0;
    end else begin
      found_r <= found_nxt;
      bytes_r <= bytes_nxt;
      ovf_r   <= ovf_nxt;
      seen_r  <= seen_nxt;
      sel_r   <= sel_nxt;
    end
  end

  fsl_out_fifo u_fifo (
    .clk         (clk),
    .rst_n       (rst_n),
    .push_cnt    (push_cnt),
    .push0       (push0),
    .push1       (push1),
    .pop         (out_valid && !out_stall),
    .not_empty   (fifo_ne),
    .almost_full (fifo_af),
    .head        (head)
  );

  assign out_valid         = fifo_ne;
  assign out_result_kind   = head.kind;
  assign out_line_number   = (head.kind == KIND_LINE)  ? head.value : '0;
  assign out_match_total   = (head.kind == KIND_COUNT) ? head.value : '0;
  assign out_was_truncated = (head.kind == KIND_LINE)  ? head.truncated : 1'b0;
  assign out_last          = head.last;

  // line state is empty right after any line end
  `FSL_ASSERT(a_line_cleared, $past(is_newline || is_end) |-> (bytes_r == '0 && !found_r && !ovf_r))
  // overflow only once the stored part is full
  `FSL_NEVER(a_ovf_early, ovf_r && has_room)
  // stream counters restart after end of input
  `FSL_ASSERT(a_end_clears, is_end |=> (seen_r == '0 && sel_r == '0))

endmodule

// ===== tb/sv/tb_fixed_string_line_filter.sv =====
module tb_fixed_string_line_filter;
  import fsl_pkg::*;

  // Run limits: worst case is a few thousand long-line bytes plus ~1k other
  // items, each with sender gaps and receiver stalls; the limit is far above.
  localparam int CYCLE_LIMIT   = 400000;
  localparam int SETTLE_CYCLES = 4;
  localparam int RANDOM_ITEMS  = 500;
  localparam int REPORT_LIMIT  = 10;

  // One result item as the checker sees it.
  typedef struct packed {
    logic        kind;
    logic [31:0] line_no;
    logic        trunc;
    logic [31:0] total;
    logic        last;
  } line_report_t;

  logic        clk          = 1'b0;
  logic        rst_n        = 1'b0;
  logic        in_valid     = 1'b0;
  logic        in_req_type  = REQ_TEXT;
  logic [7:0]  in_data_byte = 8'h00;
  logic        out_stall    = 1'b0;
  logic        cfg_valid    = 1'b0;
  logic [2:0]  cfg_index    = 3'd0;
  logic [63:0] cfg_data     = 64'd0;

  logic        in_stall;
  logic        out_valid;
  logic        out_result_kind;
  logic [31:0] out_line_number;
  logic        out_was_truncated;
  logic [31:0] out_match_total;
  logic        out_last;
  logic        cfg_ready;

  fixed_string_line_filter u_top (.*);

  // 4 time unit clock.
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor: shadow copy of the registers and of the line scanner state.
  // ---------------------------------------------------------------------------
  logic [5:0]   p_len          = '0;
  logic [255:0] p_bytes        = '0;   // pattern byte i at bits 8*i+7:8*i
  logic         p_fold         = 1'b0;
  logic         p_invert       = 1'b0;
  logic [31:0]  prefix_vec     = '0;   // bit i: pattern bytes 0..i end here
  logic         found_in_line  = 1'b0;
  int           stored_bytes   = 0;
  logic         overflow_seen  = 1'b0;
  logic [31:0]  line_count     = '0;
  logic [31:0]  selected_count = '0;

  line_report_t pending_reports [$];

  int  mismatch_count  = 0;
  int  items_sent      = 0;
  int  reports_checked = 0;
  int  cycle_count     = 0;
  bit  jitter_on       = 1'b1;   // random idling on both sides
  int  hold_request    = 0;      // receiver hold-off length, picked up below
  int  hold_left       = 0;

  function automatic logic [7:0] case_fold(logic [7:0] c);
    if (p_fold && c >= UPPER_A && c <= UPPER_Z) begin
      return c + CASE_OFFSET;
    end
    return c;
  endfunction

  // Lengths past MAX_PATTERN behave as MAX_PATTERN.
  function automatic int active_len();
    return (p_len > MAX_PATTERN) ? MAX_PATTERN : int'(p_len);
  endfunction

  // Shift-and step over one stored byte.
  function automatic void match_byte(logic [7:0] c);
    logic [31:0] eq;
    int          n;
    eq = '0;
    n  = active_len();
    for (int i = 0; i < n; i++) begin
      if (case_fold(p_bytes[8*i +: 8]) == case_fold(c)) begin
        eq[i] = 1'b1;
      end
    end
    prefix_vec = {prefix_vec[30:0], 1'b1} & eq;
    if (n > 0 && prefix_vec[n-1]) begin
      found_in_line = 1'b1;
    end
  endfunction

  function automatic void clear_line_state();
    prefix_vec    = '0;
    found_in_line = 1'b0;
    stored_bytes  = 0;
    overflow_seen = 1'b0;
  endfunction

  // Ends the open line; a selected line queues its report.
  function automatic void close_line(logic is_last);
    logic hit;
    hit = found_in_line || active_len() == 0;
    if (line_count != '1) begin
      line_count++;
    end
    if (hit != p_invert) begin
      if (selected_count != '1) begin
        selected_count++;
      end
      pending_reports.push_back({KIND_LINE, line_count, overflow_seen, 32'd0, is_last});
    end
    clear_line_state();
  endfunction

  // Works out the reports that one accepted input item causes.
  function automatic void scan_item(logic kind, logic [7:0] b);
    if (kind == REQ_TEXT) begin
      if (b != NEWLINE_BYTE) begin
        if (stored_bytes < LINE_CAPACITY - 1) begin
          stored_bytes++;
          match_byte(b);
        end else begin
          overflow_seen = 1'b1;
        end
      end else begin
        close_line(1'b1);
      end
    end else begin
      // end of stream: flush a non-empty open line, then the count
      if (stored_bytes > 0) begin
        close_line(1'b0);
      end else begin
        clear_line_state();
      end
      pending_reports.push_back({KIND_COUNT, 32'd0, 1'b0, selected_count, 1'b1});
      line_count     = '0;
      selected_count = '0;
    end
  endfunction

  function automatic void apply_reg(cfg_reg_t idx, logic [63:0] val);
    case (idx)
      REG_PATTERN_LENGTH: p_len = val[5:0];
      REG_PATTERN_WORD0:  p_bytes[63:0]    = val;
      REG_PATTERN_WORD1:  p_bytes[127:64]  = val;
      REG_PATTERN_WORD2:  p_bytes[191:128] = val;
      REG_PATTERN_WORD3:  p_bytes[255:192] = val;
      REG_IGNORE_CASE:    p_fold   = val[0];
      REG_INVERT_MATCH:   p_invert = val[0];
      default: ;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Result checking: each accepted report against the oldest expectation.
  // ---------------------------------------------------------------------------
  function automatic void note_mismatch(string what, line_report_t want, line_report_t seen);
    mismatch_count++;
    if (mismatch_count <= REPORT_LIMIT) begin
      $display("[%0t] %s: expected kind=%0d line=%0d trunc=%0d total=%0d last=%0d",
               $time, what, want.kind, want.line_no, want.trunc, want.total, want.last);
      $display("         actual   kind=%0d line=%0d trunc=%0d total=%0d last=%0d",
               seen.kind, seen.line_no, seen.trunc, seen.total, seen.last);
    end
  endfunction

  always @(posedge clk) begin : check_reports
    line_report_t want;
    line_report_t seen;
    if (rst_n && out_valid && !out_stall) begin
      seen = {out_result_kind, out_line_number, out_was_truncated, out_match_total, out_last};
      reports_checked++;
      if (pending_reports.size() == 0) begin
        note_mismatch("report with nothing expected", '0, seen);
      end else begin
        want = pending_reports.pop_front();
        if (want !== seen) begin
          note_mismatch("report mismatch", want, seen);
        end
      end
    end
  end

  // Receiver: random stalls, or a long hold-off counted here once requested.
  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_stall <= 1'b1;
    end else if (hold_request > 0) begin
      hold_left    = hold_request;
      hold_request = 0;
      out_stall <= 1'b1;
    end else begin
      out_stall <= jitter_on && ($urandom_range(99) < 12);
    end
  end

  // Watchdog.
  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles, %0d reports still expected",
             cycle_count, pending_reports.size());
    $display("TEST FAILED");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Drivers.
  // ---------------------------------------------------------------------------

  // Offers one item, sometimes after a one-cycle idle gap; predicts on accept.
  task automatic send_item(logic kind, logic [7:0] b);
    if (jitter_on && $urandom_range(99) < 12) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_req_type  <= kind;
    in_data_byte <= b;
    do @(posedge clk); while (in_stall);
    scan_item(kind, b);
    items_sent++;
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) begin
      send_item(REQ_TEXT, s[i]);
    end
  endtask

  task automatic send_line(string s);
    send_text(s);
    send_item(REQ_TEXT, NEWLINE_BYTE);
  endtask

  task automatic send_run(logic [7:0] b, int count);
    repeat (count) send_item(REQ_TEXT, b);
  endtask

  // The data byte is don't-care at end of stream, so it is randomized.
  task automatic send_end();
    send_item(REQ_END, 8'($urandom_range(255)));
  endtask

  // Drops valid, drains every expected report, then lets the scanner settle
  // so that registers can be rewritten safely.
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Valid stays up across back-to-back writes; load_config lowers it once.
  task automatic write_reg(cfg_reg_t idx, logic [63:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    apply_reg(idx, val);
  endtask

  task automatic load_config(int len, logic [255:0] pat, logic fold, logic invert);
    write_reg(REG_PATTERN_LENGTH, 64'(len));
    write_reg(REG_PATTERN_WORD0, pat[63:0]);
    write_reg(REG_PATTERN_WORD1, pat[127:64]);
    write_reg(REG_PATTERN_WORD2, pat[191:128]);
    write_reg(REG_PATTERN_WORD3, pat[255:192]);
    write_reg(REG_IGNORE_CASE, 64'(fold));
    write_reg(REG_INVERT_MATCH, 64'(invert));
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [255:0] pack_text(string s);
    logic [255:0] r;
    r = '0;
    for (int i = 0; i < s.len() && i < MAX_PATTERN; i++) begin
      r[8*i +: 8] = s[i];
    end
    return r;
  endfunction

  // Byte source biased toward case-fold boundaries and a tiny alphabet, so
  // that random lines overlap partial patterns often.
  function automatic logic [7:0] text_byte();
    case ($urandom_range(9))
      0: return 8'h00;
      1: return 8'hFF;
      2: return UPPER_A;
      3: return UPPER_Z;
      4: return UPPER_A - 8'd1;              // '@'
      5: return UPPER_Z + 8'd1;              // '['
      6: return UPPER_A + CASE_OFFSET;       // 'a'
      7: return UPPER_A + CASE_OFFSET + 8'd1;
      8: return UPPER_A + 8'd1;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  function automatic logic [7:0] flip_case(logic [7:0] b);
    logic letter;
    letter = (b >= UPPER_A && b <= UPPER_Z) ||
             (b >= UPPER_A + CASE_OFFSET && b <= UPPER_Z + CASE_OFFSET);
    return (letter && $urandom_range(1) == 1) ? (b ^ CASE_OFFSET) : b;
  endfunction

  // One random line; often carries the pattern (sometimes cut short by one
  // byte, sometimes case-flipped), occasionally left without its newline.
  task automatic random_line(int len, logic [255:0] pat);
    int nbytes;
    int at;
    int plen;
    int ins;
    plen   = (len > MAX_PATTERN) ? MAX_PATTERN : len;
    nbytes = ($urandom_range(9) == 0) ? 0 : $urandom_range(10);
    at     = ($urandom_range(2) != 0) ? $urandom_range(nbytes) : -1;
    ins    = ($urandom_range(3) == 0) ? plen - 1 : plen;
    for (int i = 0; i <= nbytes; i++) begin
      if (i == at) begin
        for (int j = 0; j < ins; j++) begin
          send_item(REQ_TEXT, flip_case(pat[8*j +: 8]));
        end
      end
      if (i < nbytes) begin
        send_item(REQ_TEXT, text_byte());
      end
    end
    if ($urandom_range(9) != 0) begin
      send_item(REQ_TEXT, NEWLINE_BYTE);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests.
  // ---------------------------------------------------------------------------

  // Reset config: empty pattern selects every line, the empty one too.
  // A second end on an empty stream gives only a zero count.
  task automatic test_empty_pattern();
    send_line("ab");
    send_item(REQ_TEXT, NEWLINE_BYTE);
    send_end();
    send_end();
    settle();
  endtask

  // Plain and case-folded search, fold boundaries, zero bytes in line and
  // pattern, and a final line without newline flushed at end.
  task automatic test_plain_match();
    logic [255:0] pat;
    load_config(3, pack_text("cat"), 1'b0, 1'b0);
    send_line("concat");
    send_line("dog");
    send_line("CAT");
    send_line("ca");
    settle();
    load_config(3, pack_text("cAt"), 1'b1, 1'b0);
    send_line("xCaTx");
    settle();
    // '@' and '[' sit just outside A-Z; their lower-case neighbors must not fold
    load_config(2, pack_text("@["), 1'b1, 1'b0);
    send_line("`{");
    send_line("@[");
    settle();
    pat = '0;
    pat[7:0]   = UPPER_A + CASE_OFFSET;
    pat[23:16] = UPPER_A + CASE_OFFSET + 8'd1;
    load_config(3, pat, 1'b0, 1'b0);
    send_item(REQ_TEXT, 8'h78);
    send_item(REQ_TEXT, pat[7:0]);
    send_item(REQ_TEXT, 8'h00);
    send_item(REQ_TEXT, pat[23:16]);
    send_item(REQ_TEXT, 8'hFF);
    send_item(REQ_TEXT, NEWLINE_BYTE);
    send_item(REQ_TEXT, pat[7:0]);
    send_item(REQ_TEXT, 8'h00);
    send_item(REQ_TEXT, pat[23:16]);
    send_end();
    settle();
  endtask

  task automatic test_invert();
    load_config(2, pack_text("ab"), 1'b0, 1'b1);
    send_line("ab");
    send_line("ba");
    send_item(REQ_TEXT, NEWLINE_BYTE);
    send_end();
    settle();
    // inverted empty pattern selects nothing
    load_config(0, '0, 1'b0, 1'b1);
    send_line("zz");
    send_end();
    settle();
  endtask

  // Full-width pattern, all-ones and all-zero words, a length past the
  // maximum, and a pattern longer than the line.
  task automatic test_wide_pattern();
    load_config(32, '1, 1'b0, 1'b0);
    send_run(8'hFF, 31);
    send_item(REQ_TEXT, NEWLINE_BYTE);
    send_run(8'hFF, 33);
    send_item(REQ_TEXT, NEWLINE_BYTE);
    settle();
    load_config(63, '1, 1'b0, 1'b0);
    send_run(8'hFF, 31);
    send_item(REQ_TEXT, NEWLINE_BYTE);
    send_run(8'hFF, 32);
    send_item(REQ_TEXT, NEWLINE_BYTE);
    settle();
    load_config(5, '0, 1'b0, 1'b0);
    send_run(8'h00, 5);
    send_item(REQ_TEXT, NEWLINE_BYTE);
    send_run(8'h00, 4);
    send_item(REQ_TEXT, NEWLINE_BYTE);
    settle();
    load_config(32, pack_text("The Quick brown fox jumps over!!"), 1'b1, 1'b0);
    send_line("<the quick BROWN fox jumps over!!>");
    send_line("the quick brown fox jumps over!");
    send_end();
    settle();
  endtask

  // Lines past the stored capacity: a match beyond it is not seen, the flag
  // is reported, a line exactly at capacity still matches, and a truncated
  // unterminated line is flushed at end.
  task automatic test_truncation();
    load_config(4, pack_text("abcd"), 1'b0, 1'b0);
    send_run(8'h78, LINE_CAPACITY - 2);
    send_line("abcd");
    send_text("abcd");
    send_run(8'h78, LINE_CAPACITY + 50);
    send_item(REQ_TEXT, NEWLINE_BYTE);
    send_run(8'h78, LINE_CAPACITY - 5);
    send_line("abcd");
    send_text("abcd");
    send_run(8'h78, LINE_CAPACITY + 2);
    send_end();
    settle();
  endtask

  // Registers change while a line is open; later bytes use the new values.
  task automatic test_midline_config();
    load_config(2, pack_text("xy"), 1'b0, 1'b0);
    send_text("ax");
    settle();
    load_config(2, pack_text("XY"), 1'b1, 1'b0);
    send_line("Y");
    send_text("q");
    settle();
    load_config(2, pack_text("xy"), 1'b0, 1'b1);
    send_item(REQ_TEXT, NEWLINE_BYTE);
    send_end();
    settle();
  endtask

  // Receiver holds off for a long stretch while every line yields a report:
  // the result queue fills and the input must stall.
  task automatic test_output_holdoff();
    load_config(0, '0, 1'b0, 1'b0);
    hold_request = 300;
    for (int i = 0; i < 40; i++) begin
      if (i % 3 == 0) begin
        send_item(REQ_TEXT, text_byte());
      end
      send_item(REQ_TEXT, NEWLINE_BYTE);
    end
    send_end();
    settle();
  endtask

  // Random phases: a fresh random setting each phase, mostly well-formed
  // lines around the pattern, with noise bytes and streams left open across
  // a register change. One phase runs with no idling on either side.
  task automatic test_random_streams(int target);
    int           start_count;
    int           phase;
    int           len;
    int           pick;
    logic [255:0] pat;
    start_count = items_sent;
    phase       = 0;
    while (items_sent - start_count < target) begin
      settle();
      jitter_on = (phase != 2);
      pick = $urandom_range(99);
      if (pick < 8) begin
        len = 0;
      end else if (pick < 70) begin
        len = $urandom_range(4, 1);
      end else if (pick < 85) begin
        len = $urandom_range(31, 5);
      end else if (pick < 92) begin
        len = MAX_PATTERN;
      end else begin
        len = $urandom_range(63, MAX_PATTERN + 1);
      end
      for (int i = 0; i < MAX_PATTERN; i++) begin
        pat[8*i +: 8] = text_byte();
      end
      load_config(len, pat, 1'($urandom_range(1)), 1'($urandom_range(3) == 0));
      repeat ((phase == 2) ? 30 : $urandom_range(12, 4)) random_line(len, pat);
      if ($urandom_range(3) != 0) begin
        send_end();
      end
      phase++;
    end
    send_end();
    jitter_on = 1'b1;
  endtask

  // ---------------------------------------------------------------------------
  // Sequence.
  // ---------------------------------------------------------------------------
  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    test_empty_pattern();
    test_plain_match();
    test_invert();
    test_wide_pattern();
    test_truncation();
    test_midline_config();
    test_output_holdoff();
    test_random_streams(RANDOM_ITEMS);
    settle();
    mismatch_count += pending_reports.size();
    $display("Line filter run: %0d bytes/end items sent, %0d reports checked, %0d failures",
             items_sent, reports_checked, mismatch_count);
    $display("Covered empty/full/oversize patterns, case folding, inversion, truncation,");
    $display("mid-line register changes, stream ends and a long receiver hold-off.");
    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
